// ----- hw/rtl/bcs_pkg.sv -----
// Shared types, codes and helper functions for the breath cycle sequencer.
package bcs_pkg;

    // Field widths.
    localparam int SpeedW  = 8;
    localparam int LenW    = 16;
    localparam int TicksW  = 24;
    localparam int CfgIdxW = 3;
    localparam int CfgW    = 16;
    localparam int InW     = 8;
    localparam int OutW    = 16;

    // Number of restoring division steps, one quotient bit each.
    localparam int DivSteps = SpeedW;
    localparam int DivCntW  = $clog2(DivSteps);

    // Action codes carried in the input word.
    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_RESTART = 2'd1,
        ACT_STOP    = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    // Motion states as reported.
    typedef enum logic [1:0] {
        MS_DISABLE = 2'd0,
        MS_IDLE    = 2'd1,
        MS_FORWARD = 2'd2,
        MS_BACK    = 2'd3
    } motion_t;

    // Configuration register indexes.
    typedef enum logic [CfgIdxW-1:0] {
        CFG_PUMPING_SPEED   = 3'd0,
        CFG_PUMPING_FORWARD = 3'd1,
        CFG_IDLE_TIME       = 3'd2,
        CFG_MAX_SPEED       = 3'd3,
        CFG_MIN_SPEED       = 3'd4,
        CFG_MIN_FORWARD     = 3'd5,
        CFG_MAX_FORWARD     = 3'd6,
        CFG_UNUSED          = 3'd7
    } cfg_idx_t;

    // Register reset values.
    localparam logic [SpeedW-1:0] RstPumpingSpeed   = 8'd127;
    localparam logic [LenW-1:0]   RstPumpingForward = 16'd600;
    localparam logic [LenW-1:0]   RstIdleTime       = 16'd4000;
    localparam logic [SpeedW-1:0] RstMaxSpeed       = 8'd255;
    localparam logic [SpeedW-1:0] RstMinSpeed       = 8'd1;
    localparam logic [LenW-1:0]   RstMinForward     = 16'd0;
    localparam logic [LenW-1:0]   RstMaxForward     = 16'd1000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // latch the input word and load the divider
        logic div_step;  // one restoring division step
        logic mul;       // register stroke length times quotient
        logic commit;    // update state and load the output register
    } bcs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;  // output register can take a word this cycle
    } bcs_sts_t;

    // Clamp with the lower bound checked first: when the bounds are crossed, a value
    // below the low bound gives the low bound and any other value the high bound.
    function automatic logic [LenW-1:0] clamp16(input logic [LenW-1:0] v,
                                                input logic [LenW-1:0] lo,
                                                input logic [LenW-1:0] hi);
        logic [LenW-1:0] r;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [SpeedW-1:0] clamp8(input logic [SpeedW-1:0] v,
                                                 input logic [SpeedW-1:0] lo,
                                                 input logic [SpeedW-1:0] hi);
        logic [SpeedW-1:0] r;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/bcs_ctrl.sv -----
// Controller state machine that sequences the accept, divide, multiply and commit steps.
module bcs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  bcs_pkg::bcs_sts_t sts,
    output bcs_pkg::bcs_cmd_t cmd
);
    import bcs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_COMMIT
    } ctrl_state_t;

    ctrl_state_t        state_reg, state_next;
    logic [DivCntW-1:0] cnt_reg, cnt_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DivCntW'(DivSteps - 1)) begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ----- hw/rtl/bcs_datapath.sv -----
// Datapath: configuration registers, speed divider, stroke multiplier, timer and output register.
module bcs_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [bcs_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [bcs_pkg::CfgW-1:0]      cfg_data,
    input  logic [bcs_pkg::InW-1:0]       s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bcs_pkg::OutW-1:0]      m_tdata,
    input  bcs_pkg::bcs_cmd_t             cmd,
    output bcs_pkg::bcs_sts_t             sts
);
    import bcs_pkg::*;

    // Configuration registers.
    logic [SpeedW-1:0] pumping_speed_reg, max_speed_reg, min_speed_reg;
    logic [LenW-1:0]   pumping_forward_reg, idle_time_reg;
    logic [LenW-1:0]   min_forward_reg, max_forward_reg;

    // Latched input word.
    action_t action_reg;
    logic    pushed_reg;

    // Sequencer state.
    motion_t           state_reg;
    logic              armed_reg;
    logic [TicksW-1:0] remain_reg;

    // Divider and multiplier.
    logic [SpeedW-1:0] divisor_reg, quo_reg, rem_reg;
    logic [TicksW-1:0] prod_reg;

    // Output register.
    logic              out_valid_reg;
    logic [OutW-1:0]   out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pumping_speed_reg   <= RstPumpingSpeed;
            pumping_forward_reg <= RstPumpingForward;
            idle_time_reg       <= RstIdleTime;
            max_speed_reg       <= RstMaxSpeed;
            min_speed_reg       <= RstMinSpeed;
            min_forward_reg     <= RstMinForward;
            max_forward_reg     <= RstMaxForward;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PUMPING_SPEED:   pumping_speed_reg   <= cfg_data[SpeedW-1:0];
                CFG_PUMPING_FORWARD: pumping_forward_reg <= cfg_data;
                CFG_IDLE_TIME:       idle_time_reg       <= cfg_data;
                CFG_MAX_SPEED:       max_speed_reg       <= cfg_data[SpeedW-1:0];
                CFG_MIN_SPEED:       min_speed_reg       <= cfg_data[SpeedW-1:0];
                CFG_MIN_FORWARD:     min_forward_reg     <= cfg_data;
                CFG_MAX_FORWARD:     max_forward_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // The stroke entered is forward on a restart or when leaving idle,
    // back otherwise. Only used when a stroke is actually entered.
    logic enter_fwd;
    assign enter_fwd = (action_reg == ACT_RESTART) || (state_reg == MS_IDLE);

    // Restoring divider for max_speed / clamped speed.
    logic [SpeedW:0]   div_shift;
    logic [SpeedW:0]   div_diff;
    logic [SpeedW-1:0] speed_clamped;
    logic [SpeedW-1:0] quotient;
    logic [LenW-1:0]   stroke_len;

    assign speed_clamped = clamp8(pumping_speed_reg, min_speed_reg, max_speed_reg);
    assign div_shift     = {rem_reg, quo_reg[SpeedW-1]};
    assign div_diff      = div_shift - {1'b0, divisor_reg};
    // A zero divisor can only come from a zero lower or upper clamp bound; the quotient is
    // then taken as max_speed itself.
    assign quotient      = (divisor_reg == '0) ? max_speed_reg : quo_reg;
    assign stroke_len    = enter_fwd
                         ? clamp16(pumping_forward_reg, min_forward_reg, max_forward_reg)
                         : clamp16(max_forward_reg, min_forward_reg, max_forward_reg);

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            action_reg  <= action_t'(s_tdata[1:0]);
            pushed_reg  <= s_tdata[2];
            divisor_reg <= speed_clamped;
            quo_reg     <= max_speed_reg;
            rem_reg     <= '0;
        end else if (cmd.div_step) begin
            if (!div_diff[SpeedW]) begin
                rem_reg <= div_diff[SpeedW-1:0];
                quo_reg <= {quo_reg[SpeedW-2:0], 1'b1};
            end else begin
                rem_reg <= div_shift[SpeedW-1:0];
                quo_reg <= {quo_reg[SpeedW-2:0], 1'b0};
            end
        end
        if (cmd.mul) begin
            prod_reg <= TicksW'(stroke_len) * TicksW'(quotient);
        end
    end

    // Commit logic: next sequencer state and the events of this word.
    motion_t           state_next, target;
    logic              armed_next, do_enter;
    logic [TicksW-1:0] remain_next;
    logic              ev_changed, ev_stop, ev_move, ev_cw;
    logic [SpeedW-1:0] ev_speed;

    always_comb begin
        state_next  = state_reg;
        armed_next  = armed_reg;
        remain_next = remain_reg;
        ev_changed  = 1'b0;
        ev_stop     = 1'b0;
        ev_move     = 1'b0;
        ev_speed    = '0;
        ev_cw       = 1'b0;
        do_enter    = 1'b0;
        target      = MS_FORWARD;

        case (action_reg)
            ACT_TICK: begin
                if ((state_reg == MS_BACK && pushed_reg) ||
                    (armed_reg && remain_reg == '0)) begin
                    case (state_reg)
                        MS_IDLE:    begin do_enter = 1'b1; target = MS_FORWARD; end
                        MS_FORWARD: begin do_enter = 1'b1; target = MS_BACK;    end
                        MS_BACK:    begin do_enter = 1'b1; target = MS_IDLE;    end
                        default: ;
                    endcase
                end else if (armed_reg) begin
                    remain_next = remain_reg - 1'b1;
                end
            end
            ACT_RESTART: begin
                do_enter = 1'b1;
                target   = MS_FORWARD;
            end
            ACT_STOP: begin
                state_next  = MS_DISABLE;
                armed_next  = 1'b0;
                remain_next = '0;
                ev_stop     = 1'b1;
                ev_changed  = 1'b1;
            end
            default: ;
        endcase

        if (do_enter) begin
            ev_changed = (state_reg != target);
            state_next = target;
            ev_stop    = 1'b1;
            armed_next = 1'b1;
            if (target == MS_IDLE) begin
                remain_next = TicksW'(idle_time_reg);
            end else begin
                remain_next = prod_reg;
                ev_move     = 1'b1;
                ev_speed    = pumping_speed_reg;
                ev_cw       = (target == MS_FORWARD);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= MS_DISABLE;
            armed_reg  <= 1'b0;
            remain_reg <= '0;
        end else if (cmd.commit) begin
            state_reg  <= state_next;
            armed_reg  <= armed_next;
            remain_reg <= remain_next;
        end
    end

    // Output register; a waiting word is held until the sink takes it.
    assign sts.out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_data_reg <= {2'b00, ev_cw, ev_speed, ev_move, ev_stop, ev_changed,
                             state_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- hw/rtl/breath_cycle_sequencer.sv -----
// Top level of the breath cycle sequencer: controller and datapath.
// A result word is valid once its accepted input word has passed through eight division
// steps, one multiply and one commit.
// The next input word is taken only after the previous one is committed; the pace is set by
// the 8-step restoring divider that forms max_speed / clamped speed for every word,
// and slows further if the sink stalls.
// Reset (aresetn, synchronous, active low) loads the default configuration and
// puts the sequencer in the disabled state with the timer disarmed.
module breath_cycle_sequencer (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Configuration write port.
    input  logic                        cfg_wr_en,
    input  logic [bcs_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [bcs_pkg::CfgW-1:0]    cfg_data,
    // Input words.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // [1:0] action, [2] switch_pushed, [7:3] zero
    input  logic [bcs_pkg::InW-1:0]     s_tdata,
    // Result words.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [1:0] motion_state, [2] state_changed, [3] stop_event, [4] move_event,
    // [12:5] move_speed, [13] move_clockwise, [15:14] zero
    output logic [bcs_pkg::OutW-1:0]    m_tdata
);
    import bcs_pkg::*;

    // The controller only takes a new word when the previous one has been
    // committed to the output register, so a result waiting on the sink
    // does not hold off the next input word.
    bcs_cmd_t cmd;
    bcs_sts_t sts;

    bcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath owns the configuration, the sequencer state, the divider,
    // the stroke multiplier and the output register.
    bcs_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ----- verif/breath_cycle_sequencer_checker.sv -----
// Channel monitor, state predictor and result comparator for the breath cycle sequencer.
`timescale 1ns / 1ps

module breath_cycle_sequencer_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [bcs_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [bcs_pkg::CfgW-1:0]    cfg_data,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [bcs_pkg::InW-1:0]     s_tdata,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [bcs_pkg::OutW-1:0]    m_tdata,
    output int                          fail_count,
    output int                          words_pending
);
    import bcs_pkg::*;

    typedef struct {
        motion_t            motion;
        logic               changed;
        logic               stopped;
        logic               moved;
        logic [SpeedW-1:0]  speed;
        logic               clockwise;
    } breath_word_t;

    breath_word_t expected_q[$];

    // Shadow copy of the configuration registers.
    logic [SpeedW-1:0] pump_speed, top_speed, low_speed;
    logic [LenW-1:0]   pump_len, pause_len, low_len, top_len;

    // Shadow copy of the sequencer state.
    motion_t           motion_now;
    logic              timer_on;
    logic [TicksW-1:0] ticks_left;

    int results_seen;

    initial begin
        fail_count    = 0;
        words_pending = 0;
        results_seen  = 0;
    end

    task automatic report_mismatch(input string msg);
        if (fail_count < 50) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        fail_count++;
    endtask

    // Low bound is tested first: when the bounds cross, a value below it gives lo, any other gives hi.
    function automatic int bound(input int v, input int lo, input int hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    function automatic logic [TicksW-1:0] stroke_ticks(input logic [LenW-1:0] len);
        int l;
        int s;
        int q;
        l = bound(len, low_len, top_len);
        s = bound(pump_speed, low_speed, top_speed);
        q = (s == 0) ? int'(top_speed) : int'(top_speed) / s;
        return TicksW'(l * q);
    endfunction

    task automatic enter_motion(input motion_t next, inout breath_word_t w);
        if (motion_now != next) begin
            w.changed = 1'b1;
        end
        motion_now = next;
        w.stopped  = 1'b1;
        if (next == MS_IDLE) begin
            ticks_left = TicksW'(pause_len);
            timer_on   = 1'b1;
        end else if (next == MS_FORWARD || next == MS_BACK) begin
            ticks_left  = stroke_ticks((next == MS_FORWARD) ? pump_len : top_len);
            timer_on    = 1'b1;
            w.moved     = 1'b1;
            w.speed     = pump_speed;
            w.clockwise = (next == MS_FORWARD);
        end
    endtask

    task automatic predict_word(input action_t act, input logic pushed,
                                output breath_word_t w);
        logic expired;
        w.changed   = 1'b0;
        w.stopped   = 1'b0;
        w.moved     = 1'b0;
        w.speed     = '0;
        w.clockwise = 1'b0;
        case (act)
            ACT_TICK: begin
                expired = timer_on && (ticks_left == '0);
                if ((motion_now == MS_BACK && pushed) || expired) begin
                    case (motion_now)
                        MS_IDLE:    enter_motion(MS_FORWARD, w);
                        MS_FORWARD: enter_motion(MS_BACK, w);
                        MS_BACK:    enter_motion(MS_IDLE, w);
                        default:    ;
                    endcase
                end else if (timer_on) begin
                    ticks_left = ticks_left - 1'b1;
                end
            end
            ACT_RESTART: enter_motion(MS_FORWARD, w);
            ACT_STOP: begin
                motion_now = MS_DISABLE;
                timer_on   = 1'b0;
                ticks_left = '0;
                w.stopped  = 1'b1;
                w.changed  = 1'b1;
            end
            default: ;
        endcase
        w.motion = motion_now;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            report_mismatch($sformatf("result %0d %s: expected %0d, got %0d",
                                      results_seen, name, want, got));
        end
    endtask

    always @(posedge aclk) begin : watch
        breath_word_t want;
        breath_word_t fresh;
        if (!aresetn) begin
            pump_speed = RstPumpingSpeed;
            pump_len   = RstPumpingForward;
            pause_len  = RstIdleTime;
            top_speed  = RstMaxSpeed;
            low_speed  = RstMinSpeed;
            low_len    = RstMinForward;
            top_len    = RstMaxForward;
            motion_now = MS_DISABLE;
            timer_on   = 1'b0;
            ticks_left = '0;
            expected_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_PUMPING_SPEED:   pump_speed = cfg_data[SpeedW-1:0];
                    CFG_PUMPING_FORWARD: pump_len   = cfg_data[LenW-1:0];
                    CFG_IDLE_TIME:       pause_len  = cfg_data[LenW-1:0];
                    CFG_MAX_SPEED:       top_speed  = cfg_data[SpeedW-1:0];
                    CFG_MIN_SPEED:       low_speed  = cfg_data[SpeedW-1:0];
                    CFG_MIN_FORWARD:     low_len    = cfg_data[LenW-1:0];
                    CFG_MAX_FORWARD:     top_len    = cfg_data[LenW-1:0];
                    default:             ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none expected",
                                              results_seen));
                end else begin
                    want = expected_q.pop_front();
                    check_field("motion_state", want.motion, m_tdata[1:0]);
                    check_field("state_changed", want.changed, m_tdata[2]);
                    check_field("stop_event", want.stopped, m_tdata[3]);
                    check_field("move_event", want.moved, m_tdata[4]);
                    check_field("move_speed", want.speed, m_tdata[12:5]);
                    check_field("move_clockwise", want.clockwise, m_tdata[13]);
                end
                results_seen++;
            end
            if (s_tvalid && s_tready) begin
                predict_word(action_t'(s_tdata[1:0]), s_tdata[2], fresh);
                expected_q.push_back(fresh);
            end
        end
        words_pending = expected_q.size();
    end

endmodule

// ----- verif/breath_cycle_sequencer_tb.sv -----
// Top of the breath cycle sequencer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module breath_cycle_sequencer_tb;
    import bcs_pkg::*;

    // Flow control modes; each stimulus phase runs under one of them.
    localparam int ModeSteady     = 0;
    localparam int ModeSlowSource = 1;
    localparam int ModeSlowSink   = 2;
    localparam int ModeBoth       = 3;

    localparam int NumPhases     = 14;
    localparam int WordsPerPhase = 110;
    // Margin waited after the last drain before the verdict.
    localparam int DrainCycles   = 24;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [CfgIdxW-1:0] cfg_index;
    logic [CfgW-1:0]    cfg_data;
    logic               s_tvalid;
    logic               s_tready;
    // [1:0] action, [2] switch_pushed, [7:3] zero
    logic [InW-1:0]     s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    // [1:0] motion_state, [2] state_changed, [3] stop_event, [4] move_event,
    // [12:5] move_speed, [13] move_clockwise, [15:14] zero
    logic [OutW-1:0]    m_tdata;

    int fail_count;
    int words_pending;
    int flow_mode;

    breath_cycle_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // The checker sees every handshake and configuration write on its own and
    // reports back only the failure count and how many results are still due.
    breath_cycle_sequencer_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // The sink stalls at random on every falling edge, as the current mode asks.
    always @(negedge aclk) begin
        case (flow_mode)
            ModeSlowSink: m_tready <= ($urandom_range(99) >= 88);
            ModeBoth:     m_tready <= ($urandom_range(99) >= 24);
            default:      m_tready <= 1'b1;
        endcase
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Number of idle cycles the source inserts before its next word.
    function automatic int source_gap();
        int gap;
        int pct;
        gap = 0;
        case (flow_mode)
            ModeSlowSource: pct = 88;
            ModeBoth:       pct = 24;
            default:        pct = 0;
        endcase
        while ($urandom_range(99) < pct) begin
            gap++;
        end
        return gap;
    endfunction

    // Presents one word and returns once it has been taken. Valid is left high
    // so that a following word can go out back to back.
    task automatic send_word(input action_t act, input logic pushed);
        int gap;
        gap = source_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(InW - 3){1'b0}}, pushed, act};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    // Mostly ticks so that timers run out and the cycle goes round; restarts
    // pull the sequencer back out of the disabled state after a stop.
    task automatic send_random_word();
        int pick;
        action_t act;
        pick = $urandom_range(99);
        if (pick < 85) begin
            act = ACT_TICK;
        end else if (pick < 92) begin
            act = ACT_RESTART;
        end else if (pick < 96) begin
            act = ACT_STOP;
        end else begin
            act = ACT_NONE;
        end
        send_word(act, $urandom_range(99) < 30);
    endtask

    // Drops valid and waits until every result has come back.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (words_pending != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CfgW-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
    endtask

    // Writes all seven registers, then releases the write enable.
    task automatic write_config(input logic [SpeedW-1:0] speed,
                                input logic [LenW-1:0]   fwd_len,
                                input logic [LenW-1:0]   pause,
                                input logic [SpeedW-1:0] speed_hi,
                                input logic [SpeedW-1:0] speed_lo,
                                input logic [LenW-1:0]   len_lo,
                                input logic [LenW-1:0]   len_hi);
        write_reg(CFG_PUMPING_SPEED, CfgW'(speed));
        write_reg(CFG_PUMPING_FORWARD, fwd_len);
        write_reg(CFG_IDLE_TIME, pause);
        write_reg(CFG_MAX_SPEED, CfgW'(speed_hi));
        write_reg(CFG_MIN_SPEED, CfgW'(speed_lo));
        write_reg(CFG_MIN_FORWARD, len_lo);
        write_reg(CFG_MAX_FORWARD, len_hi);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Settings for one random phase. The first few phases are fixed corner
    // cases; the rest keep strokes short so that many breaths complete.
    task automatic configure_phase(input int phase);
        int speed_hi;
        case (phase)
            0: write_config(8'd255, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255,
                            16'hFFFF, 16'hFFFF);
            1: write_config(8'd0, 16'd0, 16'd0, 8'd1, 8'd1, 16'd0, 16'd0);
            // A zero lower speed bound lets the clamped speed reach zero,
            // in which case the quotient falls back to the upper speed bound.
            2: write_config(8'd0, 16'd2, 16'd1, 8'd3, 8'd0, 16'd0, 16'd3);
            // Both clamps have their bounds crossed.
            3: write_config(8'd100, 16'd1, 16'd2, 8'd10, 8'd200, 16'd5, 16'd2);
            default: begin
                speed_hi = $urandom_range(1, 255);
                write_config(SpeedW'($urandom_range(speed_hi / 2, 255)),
                             LenW'($urandom_range(0, 12)),
                             LenW'($urandom_range(0, 10)), SpeedW'(speed_hi),
                             SpeedW'(($urandom_range(3) == 0) ? $urandom_range(1, 255)
                                                              : $urandom_range(1, speed_hi)),
                             LenW'($urandom_range(0, 4)), LenW'($urandom_range(0, 10)));
            end
        endcase
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        flow_mode = ModeSteady;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // A short look at the reset configuration: a forward stroke loaded from
        // the default length and speed, then a stop.
        send_word(ACT_RESTART, 1'b0);
        send_word(ACT_TICK, 1'b0);
        send_word(ACT_STOP, 1'b0);
        drain();

        // Directed walk with one-tick forward, two-tick back and zero idle time.
        write_config(8'd255, 16'd1, 16'd0, 8'd255, 8'd1, 16'd0, 16'd2);
        send_word(ACT_TICK, 1'b1);     // tick while disabled does nothing
        send_word(ACT_STOP, 1'b0);     // stop while already disabled
        send_word(ACT_NONE, 1'b0);     // unused action code
        send_word(ACT_RESTART, 1'b0);
        send_word(ACT_RESTART, 1'b0);  // restart from forward itself
        send_word(ACT_TICK, 1'b0);
        send_word(ACT_TICK, 1'b0);     // forward times out into back
        send_word(ACT_TICK, 1'b1);     // limit switch ends back at once
        send_word(ACT_TICK, 1'b0);     // zero idle time expires at once
        send_word(ACT_TICK, 1'b1);     // switch is ignored in forward
        send_word(ACT_TICK, 1'b0);
        send_word(ACT_TICK, 1'b0);
        send_word(ACT_TICK, 1'b0);
        send_word(ACT_TICK, 1'b0);     // back times out into idle
        send_word(ACT_NONE, 1'b1);
        send_word(ACT_RESTART, 1'b0);  // restart from idle
        send_word(ACT_STOP, 1'b0);
        send_word(ACT_TICK, 1'b1);
        send_word(ACT_RESTART, 1'b0);
        send_word(ACT_TICK, 1'b0);
        send_word(ACT_TICK, 1'b0);
        send_word(ACT_RESTART, 1'b0);  // restart from back
        send_word(ACT_STOP, 1'b0);
        drain();

        // Random phases, each with fresh settings and a flow control mode.
        for (int phase = 0; phase < NumPhases; phase++) begin
            configure_phase(phase);
            case (phase % 4)
                0:       flow_mode = ModeSteady;
                1:       flow_mode = ModeSlowSource;
                2:       flow_mode = ModeSlowSink;
                default: flow_mode = ModeBoth;
            endcase
            for (int n = 0; n < WordsPerPhase; n++) begin
                send_random_word();
            end
            drain();
        end

        repeat (DrainCycles) @(negedge aclk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/bcs_pkg.sv
hw/rtl/bcs_ctrl.sv
hw/rtl/bcs_datapath.sv
hw/rtl/breath_cycle_sequencer.sv
verif/breath_cycle_sequencer_checker.sv
verif/breath_cycle_sequencer_tb.sv
